// ----- design/modexp_pkg.sv -----
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants and types for the 64-bit modular exponentiation engine.
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

    // operand width: registers, base and result are taken in these bits
    localparam int OPERAND_BITS = 64;
    localparam int CNT_W        = $clog2(OPERAND_BITS);

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 2'd1;

    // reset values of the configuration registers
    localparam logic [OPERAND_BITS-1:0] MODULUS_RESET  = OPERAND_BITS'(64'd1);
    localparam logic [OPERAND_BITS-1:0] EXPONENT_RESET = OPERAND_BITS'(64'd65537);

    // operand select for the serial modular multiplier
    typedef enum logic [1:0] {
        OP_REDUCE  = 2'd0,
        OP_MUL_ACC = 2'd1,
        OP_MUL_SQ  = 2'd2
    } op_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture base and exponent, set result to 1 mod m, clear partial
        logic prep;       // load square into multiplier shift reg, clear partial
        logic step;       // one shift-and-add step of the multiplier
        op_t  op;         // which operand feeds the step
        logic write_sq;   // store finished product into square register
        logic write_acc;  // store finished product into result register
        logic shift_exp;  // advance the exponent scan by one bit
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic exp_bit;    // current exponent bit under scan
    } status_t;

endpackage : modexp_pkg

`default_nettype wire

// ----- design/modular_exponentiation_64_top.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation_64_top
// Right-to-left binary modular exponentiation, base^exponent mod modulus.
//
// Channel   Signals                               Transaction at
// input     start, busy, base_value               start & !busy
// result    done, power_result                    done (one cycle, no stall)
// config    cfg_valid, cfg_ready, cfg_index,      cfg_valid & cfg_ready
//           cfg_data
//
// An operation reduces the base, then for each of the W = 64 exponent bits multiplies
// into the result if the bit is set, and squares; each product is bit-serial.
// The bit-serial modular multiplier does one step a cycle.
// Reset loads modulus 1 and exponent 65537. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_64_top
    import modexp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // operation
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [63:0]               base_value,
    // result
    output logic                           done,
    output logic      [63:0]               power_result,
    // configuration
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [63:0]               cfg_data
);

    cmd_t    cmd;
    status_t status;

    // registers are always writable
    assign cfg_ready = 1'b1;

    modexp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    modexp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .base_value   (base_value),
        .power_result (power_result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule : modular_exponentiation_64_top

`default_nettype wire

// ----- design/modexp_dp.sv -----
// ----------------------------------------------------------------------------
// modexp_dp
// Datapath: configuration registers, square and result registers, and a
// bit-serial modular multiplier doing one shift-and-add step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_dp
    import modexp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration write
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [63:0]               cfg_data,
    // operand and result
    input  wire logic [63:0]               base_value,
    output logic      [63:0]               power_result,
    // controller link
    input  wire cmd_t                      cmd,
    output status_t                        status
);

    localparam int W = OPERAND_BITS;

    logic [W-1:0] modulus_reg, modulus_next;
    logic [W-1:0] exponent_reg, exponent_next;
    logic [W-1:0] exp_sh_reg, exp_sh_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] sq_reg, sq_next;
    logic [W-1:0] y_reg, y_next;
    logic [W-1:0] r_reg, r_next;

    logic [W-1:0] cfg_value;
    logic [W-1:0] x_sel;
    logic [W-1:0] acc_init;
    logic [W+1:0] sum;
    logic [W+1:0] m1;
    logic [W+1:0] m2;
    logic [W-1:0] r_step;

    assign cfg_value = cfg_data[W-1:0];

    // configuration registers; a zero modulus write is dropped
    always_comb
    begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_write)
        begin
            if (cfg_index == REG_MODULUS && cfg_value != '0)
                modulus_next = cfg_value;
            else if (cfg_index == REG_EXPONENT)
                exponent_next = cfg_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MODULUS_RESET;
            exponent_reg <= EXPONENT_RESET;
        end
        else
        begin
            modulus_reg  <= modulus_next;
            exponent_reg <= exponent_next;
        end
    end

    // multiplier operand select
    always_comb
    begin
        unique case (cmd.op)
            OP_REDUCE:  x_sel = W'(1);
            OP_MUL_ACC: x_sel = acc_reg;
            OP_MUL_SQ:  x_sel = sq_reg;
            default:    x_sel = '0;
        endcase
    end

    // one step: r = (2r + ybit*x) mod m, sum stays below 3m
    assign m1  = {2'b00, modulus_reg};
    assign m2  = {1'b0, modulus_reg, 1'b0};
    assign sum = {1'b0, r_reg, 1'b0} + {2'b00, x_sel & {W{y_reg[W-1]}}};

    always_comb
    begin
        priority if (sum >= m2)
            r_step = W'(sum - m2);
        else if (sum >= m1)
            r_step = W'(sum - m1);
        else
            r_step = sum[W-1:0];
    end

    // 1 mod m
    assign acc_init = (modulus_reg == W'(1)) ? '0 : W'(1);

    // working registers
    always_comb
    begin
        r_next      = r_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        exp_sh_next = exp_sh_reg;
        if (cmd.load)
        begin
            r_next      = '0;
            y_next      = base_value[W-1:0];
            acc_next    = acc_init;
            exp_sh_next = exponent_reg;
        end
        if (cmd.prep)
        begin
            r_next = '0;
            y_next = sq_reg;
        end
        if (cmd.step)
        begin
            r_next = r_step;
            y_next = {y_reg[W-2:0], 1'b0};
        end
        if (cmd.write_sq)
            sq_next = r_step;
        if (cmd.write_acc)
            acc_next = r_step;
        if (cmd.shift_exp)
            exp_sh_next = {1'b0, exp_sh_reg[W-1:1]};
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        exp_sh_reg <= exp_sh_next;
    end

    assign status.exp_bit = exp_sh_reg[0];
    assign power_result   = 64'(acc_reg);

endmodule : modexp_dp

`default_nettype wire

// ----- design/modexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// modexp_ctrl
// Controller: sequences base reduction, then per exponent bit an optional
// multiply into the result and a squaring, each over OPERAND_BITS steps.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_ctrl
    import modexp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    output logic         done,
    output cmd_t         cmd,
    input  wire status_t status
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_REDUCE  = 7'b0000010,
        ST_BIT     = 7'b0000100,
        ST_MUL_ACC = 7'b0001000,
        ST_SQ_PREP = 7'b0010000,
        ST_MUL_SQ  = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } state_t;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(OPERAND_BITS - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  bit_reg, bit_next;
    logic              step_last;

    assign step_last = (step_reg == LAST);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        cmd.op     = OP_REDUCE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    bit_next   = '0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.step  = 1'b1;
                cmd.op    = OP_REDUCE;
                step_next = step_reg + CNT_W'(1);
                if (step_last)
                begin
                    cmd.write_sq = 1'b1;
                    state_next   = ST_BIT;
                end
            end
            ST_BIT:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = status.exp_bit ? ST_MUL_ACC : ST_MUL_SQ;
            end
            ST_MUL_ACC:
            begin
                cmd.step  = 1'b1;
                cmd.op    = OP_MUL_ACC;
                step_next = step_reg + CNT_W'(1);
                if (step_last)
                begin
                    cmd.write_acc = 1'b1;
                    state_next    = ST_SQ_PREP;
                end
            end
            ST_SQ_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_MUL_SQ;
            end
            ST_MUL_SQ:
            begin
                cmd.step  = 1'b1;
                cmd.op    = OP_MUL_SQ;
                step_next = step_reg + CNT_W'(1);
                if (step_last)
                begin
                    cmd.write_sq  = 1'b1;
                    cmd.shift_exp = 1'b1;
                    bit_next      = bit_reg + CNT_W'(1);
                    state_next    = (bit_reg == LAST) ? ST_FINISH : ST_BIT;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_FINISH);

endmodule : modexp_ctrl

`default_nettype wire

// ----- bench/tb_modular_exponentiation_64_top.sv -----
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_64_top
// Self-checking bench for the 64-bit modular exponentiation engine. A queue
// of base values feeds a clocked driver; a clocked monitor checks each result
// against a local model of base^exponent mod modulus. Key registers are
// loaded between phases, while the engine is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_modular_exponentiation_64_top
    import modexp_pkg::*;
();

    // register indexes the engine does not decode
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

    localparam int QUIET_LIMIT = 40000;
    localparam int TAIL_CYCLES = 9000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [63:0]               base_value = '0;
    logic                      done;
    logic [63:0]               power_result;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MODULUS;
    logic [63:0]               cfg_data = '0;

    // bench copy of the key registers
    logic [63:0] key_modulus  = MODULUS_RESET;
    logic [63:0] key_exponent = EXPONENT_RESET;

    logic [63:0] pending_bases[$];
    logic [63:0] expected_powers[$];
    int          send_idle_pct = 0;
    int          error_count   = 0;
    int          quiet_cycles  = 0;

    modular_exponentiation_64_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .base_value   (base_value),
        .done         (done),
        .power_result (power_result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // exact double-width product, reduced
    function automatic logic [63:0] mul_reduce(input logic [63:0] x, input logic [63:0] y,
                                               input logic [63:0] m);
        logic [127:0] product;
        product = {64'd0, x} * {64'd0, y};
        return 64'(product % {64'd0, m});
    endfunction

    // right-to-left square and multiply
    function automatic logic [63:0] predict_power(input logic [63:0] base,
                                                  input logic [63:0] exp_bits,
                                                  input logic [63:0] m);
        logic [63:0] square;
        logic [63:0] acc;
        int          i;
        square = base % m;
        acc    = 64'd1 % m;
        for (i = 0; i < OPERAND_BITS; i++)
        begin
            if (exp_bits[i])
                acc = mul_reduce(acc, square, m);
            square = mul_reduce(square, square, m);
        end
        return acc;
    endfunction

    // one write transaction on the configuration channel
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [63:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        // zero modulus and unknown indexes leave the key as it was
        if (index == REG_MODULUS)
        begin
            if (data != 64'd0)
                key_modulus = data;
        end
        else if (index == REG_EXPONENT)
            key_exponent = data;
    endtask

    task automatic load_key(input logic [63:0] modulus, input logic [63:0] exp_bits);
        write_register(REG_MODULUS, modulus);
        write_register(REG_EXPONENT, exp_bits);
    endtask

    // block until every queued base has been accepted and answered
    task automatic drain_results();
        while (pending_bases.size() != 0 || expected_powers.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] pick_modulus();
        case ($urandom_range(3))
            0: return rand_word();
            1: return 64'($urandom_range(1000));
            2: return {1'b1, rand_word() >> 1};
            default: return rand_word() >> $urandom_range(63);
        endcase
    endfunction

    function automatic logic [63:0] pick_exponent();
        case ($urandom_range(3))
            0: return rand_word();
            1: return 64'd65537;
            2: return 64'($urandom_range(15));
            default: return rand_word() >> $urandom_range(63);
        endcase
    endfunction

    function automatic logic [63:0] pick_base();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return ALL_ONES;
            2: return key_modulus - 64'd1;
            3: return key_modulus + 64'($urandom_range(3));
            default: return rand_word();
        endcase
    endfunction

    // driver: start is re-decided every cycle, so it also toggles while busy
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                expected_powers.push_back(predict_power(base_value, key_exponent,
                                                        key_modulus));
                void'(pending_bases.pop_front());
            end
            if (pending_bases.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                start      <= 1'b1;
                base_value <= pending_bases[0];
            end
            else
            begin
                start      <= 1'b0;
                base_value <= rand_word();
            end
        end
    end

    // monitor: one result per done strobe
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_powers.size() == 0)
            begin
                $error("power_result: unexpected result %h", power_result);
                error_count++;
            end
            else
            begin
                if (power_result !== expected_powers[0])
                begin
                    $error("power_result mismatch: expected %h, actual %h",
                           expected_powers[0], power_result);
                    error_count++;
                end
                void'(expected_powers.pop_front());
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("modular_exponentiation_64_top test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset key: modulus of one gives zero for every base
        send_idle_pct = 20;
        pending_bases.push_back(64'd0);
        pending_bases.push_back(ALL_ONES);
        pending_bases.push_back(rand_word());
        drain_results();

        // zero modulus and unknown indexes are ignored; modulus one, exponent zero
        write_register(REG_MODULUS, 64'd0);
        write_register(REG_SPARE_2, rand_word());
        write_register(REG_SPARE_3, rand_word());
        write_register(REG_EXPONENT, 64'd0);
        pending_bases.push_back(64'd5);
        drain_results();

        // exponent zero: one for any base, including zero
        send_idle_pct = 0;
        write_register(REG_MODULUS, ALL_ONES);
        pending_bases.push_back(64'd0);
        pending_bases.push_back(ALL_ONES);
        drain_results();

        // all exponent bits set: longest operation
        write_register(REG_EXPONENT, ALL_ONES);
        pending_bases.push_back(64'd0);
        pending_bases.push_back(64'd1);
        pending_bases.push_back(64'd2);
        pending_bases.push_back(ALL_ONES);
        pending_bases.push_back(ALL_ONES - 64'd1);
        drain_results();

        // small modulus, bases above and below it, zero write ignored again
        send_idle_pct = 63;
        load_key(64'd97, 64'd3);
        write_register(REG_MODULUS, 64'd0);
        pending_bases.push_back(64'd100);
        pending_bases.push_back(64'd96);
        pending_bases.push_back(64'd0);
        drain_results();

        // largest 64-bit prime with the usual public exponent
        load_key(PRIME_64, 64'd65537);
        pending_bases.push_back(ALL_ONES);
        pending_bases.push_back(PRIME_64);
        pending_bases.push_back(PRIME_64 + 64'd1);
        pending_bases.push_back(64'h8000_0000_0000_0000);
        drain_results();

        // exponent one, then only the top exponent bit
        write_register(REG_EXPONENT, 64'd1);
        pending_bases.push_back(ALL_ONES);
        drain_results();
        write_register(REG_EXPONENT, 64'h8000_0000_0000_0000);
        pending_bases.push_back(rand_word());
        drain_results();

        // random phases, each with a fresh key and its own idling
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase % 3)
                0: send_idle_pct = 0;
                1: send_idle_pct = 63;
                default: send_idle_pct = 20;
            endcase
            load_key(pick_modulus(), pick_exponent());
            if ($urandom_range(3) == 0)
                write_register($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, rand_word());
            if ($urandom_range(4) == 0)
                write_register(REG_MODULUS, 64'd0);
            for (n = 0; n < 17; n++)
                pending_bases.push_back(pick_base());
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("modular_exponentiation_64_top test passed");
        else
            $display("modular_exponentiation_64_top test failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/modexp_pkg.sv
design/modexp_dp.sv
design/modexp_ctrl.sv
design/modular_exponentiation_64_top.sv
bench/tb_modular_exponentiation_64_top.sv
